// File: hw/rtl/tadc_pkg.sv
// shared constants, resistance table and types for the thermistor temperature block
package tadc_pkg;

   // field widths
   localparam int CODE_W  = 12;
   localparam int TEMP_W  = 8;
   localparam int CLAMP_W = 2;
   localparam int RES_W   = 29;
   localparam int TBL_W   = 23;
   localparam int NUM_W   = 32;
   localparam int IDX_W   = 8;

   // defaults for the top level parameters
   localparam int DEF_TABLE_ENTRIES  = 131;
   localparam int DEF_ADC_FULL_SCALE = 4096;
   localparam int STORED_ENTRIES     = 131;

   // coldest table temperature and saturated resistance
   localparam logic signed [TEMP_W-1:0] FIRST_TEMP = -8'sd20;
   localparam logic [RES_W-1:0]         RES_QMAX   = '1;

   // clamp status codes
   localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
   localparam logic [CLAMP_W-1:0] CLAMP_COLD = 2'd1;
   localparam logic [CLAMP_W-1:0] CLAMP_HOT  = 2'd2;

   typedef logic [TBL_W-1:0] tadc_q16_table_type [STORED_ENTRIES];

   // thermistor resistance per degree from -20 C, in units of 1e-5 kilohm
   localparam int RES_E5 [STORED_ENTRIES] = '{
      11526600, 10814600, 10151700, 9634230, 8958650, 8421900, 7931100, 7453600,
      7016980, 6608980, 6227560, 5870790, 5636940, 5224380, 4931610, 4657250,
      4400000, 4158780, 3982390, 3719880, 3520240, 3332690, 3156350, 2990580,
      2834590, 2687780, 2549540, 2419320, 2256620, 2180940, 2071840, 1968910,
      1871770, 1780050, 1693410, 1611560, 1534180, 1461810, 1391800, 1326310,
      1264310, 1205610, 1150000, 1097310, 1047360, 1000000, 955074, 912445,
      871983, 833566, 797078, 762411, 729464, 698142, 668355, 640021,
      613059, 587359, 562961, 539689, 517519, 496392, 476253, 457050,
      438736, 421263, 404589, 388673, 373476, 358962, 345097, 331847,
      319183, 307075, 295896, 284421, 273823, 263682, 253973, 244677,
      235774, 227249, 219073, 211241, 203732, 196532, 189627, 183003,
      176647, 170547, 164691, 159068, 153668, 148481, 143498, 138703,
      134105, 129078, 125423, 121330, 117393, 113604, 109958, 106448,
      103069, 99815, 96681, 93662, 90753, 87950, 85248, 82643,
      80132, 77709, 75373, 73119, 70944, 68844, 66818, 64862,
      62973, 61148, 59387, 57683, 56038, 54448, 52912, 51426,
      49989, 48600, 47256
   };

   // table converted to Q7.16 with round half up, worked out at elaboration
   function automatic tadc_q16_table_type build_q16();
      tadc_q16_table_type t;
      for (int i = 0; i < STORED_ENTRIES; i++) begin
         t[i] = TBL_W'((64'(RES_E5[i]) * 64'd65536 + 64'd50000) / 64'd100000);
      end
      return t;
   endfunction

   localparam tadc_q16_table_type RES_Q16 = build_q16();

   // result of the table search
   typedef struct packed {
      logic [IDX_W-1:0]   tbl_index;
      logic [CLAMP_W-1:0] clamp;
   } tadc_pick_type;

   // sequencer states
   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_DIV,
      TOP_LOOK
   } tadc_top_state_type;

   typedef enum logic [3:0] {
      LK_FILL,
      LK_IDLE,
      LK_RD_FIRST,
      LK_CHK_FIRST,
      LK_RD_LAST,
      LK_CHK_LAST,
      LK_RD_MID,
      LK_CHK_MID,
      LK_PICK
   } tadc_lk_state_type;

endpackage

// File: hw/rtl/tadc_ram.sv
// generic single write port ram with registered read
module tadc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/tadc_div.sv
// bit serial divider forming the thermistor resistance in q13.16
module tadc_div
   import tadc_pkg::*;
#(
   parameter int ADC_FULL_SCALE = DEF_ADC_FULL_SCALE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CODE_W-1:0] code,
   output logic              done,
   output logic [RES_W-1:0]  res
);

   localparam int FS_W  = $clog2(ADC_FULL_SCALE + 1);
   localparam int DEN_W = FS_W + 3;
   localparam int REM_W = DEN_W + 1;
   localparam int CNT_W = $clog2(NUM_W);

   logic             run_ff, run_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             sat_ff, sat_in;
   logic             done_ff, done_in;
   logic [RES_W-1:0] res_ff, res_in;

   logic [31:0]      code_wide;
   logic             in_span;
   logic [FS_W-1:0]  span;
   logic [DEN_W-1:0] den_start;
   logic [15:0]      num9;
   logic [REM_W-1:0] trial;
   logic             take;
   logic [NUM_W-1:0] quo_next;

   // operands: 9*code*65536 over 5*(full scale - code)
   always_comb begin
      code_wide = 32'(code);
      in_span   = code_wide < 32'(ADC_FULL_SCALE);
      span      = FS_W'(32'(ADC_FULL_SCALE) - code_wide);
      den_start = (DEN_W'(span) << 2) + DEN_W'(span);
      num9      = (16'(code) << 3) + 16'(code);
   end

   // one quotient bit per cycle
   always_comb begin
      trial    = {rem_ff, num_ff[NUM_W-1]};
      take     = trial >= {1'b0, den_ff};
      quo_next = {quo_ff[NUM_W-2:0], take};

      run_in  = run_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      sat_in  = sat_ff;
      done_in = 1'b0;
      res_in  = res_ff;

      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(NUM_W - 1);
         num_in = {num9, 16'd0};
         rem_in = '0;
         quo_in = '0;
         den_in = den_start;
         sat_in = !in_span;
      end else if (run_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         rem_in = take ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         quo_in = quo_next;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            // saturate past the q13.16 range or when the divider has no value
            if (sat_ff || (|quo_next[NUM_W-1:RES_W])) begin
               res_in = RES_QMAX;
            end else begin
               res_in = quo_next[RES_W-1:0];
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      sat_ff <= sat_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

// File: hw/rtl/tadc_lookup.sv
// resistance table in ram, filled after reset, with a binary search for the nearest entry
module tadc_lookup
   import tadc_pkg::*;
#(
   parameter int ENTRIES = DEF_TABLE_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [RES_W-1:0] res,
   output logic             ready,
   output logic             done,
   output tadc_pick_type    pick
);

   localparam int AW = $clog2(ENTRIES);
   localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

   tadc_lk_state_type state_ff, state_in;
   logic [AW-1:0]     fill_ff, fill_in;
   logic [RES_W-1:0]  r_ff, r_in;
   logic [AW-1:0]     lo_ff, lo_in;
   logic [AW-1:0]     hi_ff, hi_in;
   logic [TBL_W-1:0]  lo_val_ff, lo_val_in;
   logic [TBL_W-1:0]  hi_val_ff, hi_val_in;
   logic              done_ff, done_in;
   tadc_pick_type     pick_ff, pick_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [TBL_W-1:0]  wr_data;
   logic [AW-1:0]     rd_addr;
   logic [TBL_W-1:0]  rd_data;

   logic [AW:0]       mid_sum;
   logic [AW-1:0]     mid;
   logic [RES_W-1:0]  rd_wide;
   logic [RES_W-1:0]  dist_up;
   logic [RES_W-1:0]  dist_dn;

   tadc_ram #(
      .WIDTH (TBL_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // search helpers
   always_comb begin
      mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
      mid     = mid_sum[AW:1];
      rd_wide = RES_W'(rd_data);
      dist_up = RES_W'(lo_val_ff) - r_ff;
      dist_dn = r_ff - RES_W'(hi_val_ff);
   end

   // next state and outputs
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      r_in      = r_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      lo_val_in = lo_val_ff;
      hi_val_in = hi_val_ff;
      done_in   = 1'b0;
      pick_in   = pick_ff;
      wr_en     = 1'b0;
      wr_addr   = fill_ff;
      wr_data   = RES_Q16[fill_ff];
      rd_addr   = '0;

      case (state_ff)
         LK_FILL: begin
            wr_en   = 1'b1;
            fill_in = fill_ff + AW'(1);
            if (fill_ff == LAST) begin
               state_in = LK_IDLE;
            end
         end
         LK_IDLE: begin
            if (go) begin
               r_in     = res;
               state_in = LK_RD_FIRST;
            end
         end
         LK_RD_FIRST: begin
            rd_addr  = '0;
            state_in = LK_CHK_FIRST;
         end
         LK_CHK_FIRST: begin
            lo_val_in = rd_data;
            if (r_ff > rd_wide) begin
               pick_in.tbl_index = '0;
               pick_in.clamp     = CLAMP_COLD;
               done_in           = 1'b1;
               state_in          = LK_IDLE;
            end else begin
               state_in = LK_RD_LAST;
            end
         end
         LK_RD_LAST: begin
            rd_addr  = LAST;
            state_in = LK_CHK_LAST;
         end
         LK_CHK_LAST: begin
            hi_val_in = rd_data;
            lo_in     = AW'(1);
            hi_in     = LAST;
            if (r_ff < rd_wide) begin
               pick_in.tbl_index = IDX_W'(LAST);
               pick_in.clamp     = CLAMP_HOT;
               done_in           = 1'b1;
               state_in          = LK_IDLE;
            end else if (LAST == AW'(1)) begin
               state_in = LK_PICK;
            end else begin
               state_in = LK_RD_MID;
            end
         end
         LK_RD_MID: begin
            rd_addr  = mid;
            state_in = LK_CHK_MID;
         end
         LK_CHK_MID: begin
            // narrow to the first entry at or below the resistance
            if (rd_wide <= r_ff) begin
               hi_in     = mid;
               hi_val_in = rd_data;
               state_in  = (lo_ff == mid) ? LK_PICK : LK_RD_MID;
            end else begin
               lo_in     = mid + AW'(1);
               lo_val_in = rd_data;
               state_in  = ((mid + AW'(1)) == hi_ff) ? LK_PICK : LK_RD_MID;
            end
         end
         LK_PICK: begin
            // nearer end of the interval, the colder one on a tie
            if (dist_up <= dist_dn) begin
               pick_in.tbl_index = IDX_W'(lo_ff - AW'(1));
            end else begin
               pick_in.tbl_index = IDX_W'(lo_ff);
            end
            pick_in.clamp = CLAMP_NONE;
            done_in       = 1'b1;
            state_in      = LK_IDLE;
         end
         default: begin
            state_in = LK_FILL;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LK_FILL;
         fill_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         done_ff  <= done_in;
      end
   end

   // search registers
   always_ff @(posedge clock) begin
      r_ff      <= r_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      lo_val_ff <= lo_val_in;
      hi_val_ff <= hi_val_in;
      pick_ff   <= pick_in;
   end

   assign ready = state_ff == LK_IDLE;
   assign done  = done_ff;
   assign pick  = pick_ff;

endmodule

// File: hw/rtl/thermistor_adc_to_temperature_core.sv
// top level: adc code to nearest table temperature with clamp status
//
// Command channel: a word (req_adc_code) is taken at a rising edge where start
// is high and busy is low. One item is worked on at a time; busy stays high
// until its result has been registered.
// Result channel: rsp_valid is high for exactly one cycle with
// rsp_temperature_c and rsp_clamp_status; the receiver cannot stall it and
// must take the word in that cycle.
// The accepted code passes through the bit serial divider, then the table
// search in ram, each probe a registered ram read. A cold end clamp is found
// once the first entry is read, a hot end clamp once the last is read, and an
// in range value then takes a binary search of about ceil(log2(entries - 1)) steps.
// busy drops at the edge that raises rsp_valid, so the next command can be
// taken while the result is shown.
// Reset: the resistance table is copied into the ram, one entry a cycle;
// busy is high for that time.
module thermistor_adc_to_temperature_core
   import tadc_pkg::*;
#(
   parameter int TABLE_ENTRIES  = DEF_TABLE_ENTRIES,
   parameter int ADC_FULL_SCALE = DEF_ADC_FULL_SCALE
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [CODE_W-1:0]        req_adc_code,
   output logic                     rsp_valid,
   output logic signed [TEMP_W-1:0] rsp_temperature_c,
   output logic [CLAMP_W-1:0]       rsp_clamp_status
);

   localparam int TABLE_USED = (TABLE_ENTRIES > STORED_ENTRIES) ? STORED_ENTRIES :
                               (TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES;

   tadc_top_state_type        state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [TEMP_W-1:0]  rsp_temp_ff, rsp_temp_in;
   logic [CLAMP_W-1:0]        rsp_clamp_ff, rsp_clamp_in;

   logic                      accept;
   logic                      div_done;
   logic [RES_W-1:0]          div_res;
   logic                      lk_ready;
   logic                      lk_done;
   tadc_pick_type             lk_pick;

   tadc_div #(
      .ADC_FULL_SCALE (ADC_FULL_SCALE)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .code  (req_adc_code),
      .done  (div_done),
      .res   (div_res)
   );

   tadc_lookup #(
      .ENTRIES (TABLE_USED)
   ) u_lookup (
      .clock (clock),
      .reset (reset),
      .go    (div_done),
      .res   (div_res),
      .ready (lk_ready),
      .done  (lk_done),
      .pick  (lk_pick)
   );

   // sequencing of divider and search, and the result word
   always_comb begin
      busy         = (state_ff != TOP_IDLE) || !lk_ready;
      accept       = start && !busy;
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_temp_in  = rsp_temp_ff;
      rsp_clamp_in = rsp_clamp_ff;

      case (state_ff)
         TOP_IDLE: begin
            if (accept) begin
               state_in = TOP_DIV;
            end
         end
         TOP_DIV: begin
            if (div_done) begin
               state_in = TOP_LOOK;
            end
         end
         TOP_LOOK: begin
            if (lk_done) begin
               rsp_valid_in = 1'b1;
               rsp_temp_in  = $signed(lk_pick.tbl_index + $unsigned(FIRST_TEMP));
               rsp_clamp_in = lk_pick.clamp;
               state_in     = TOP_IDLE;
            end
         end
         default: begin
            state_in = TOP_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      rsp_temp_ff  <= rsp_temp_in;
      rsp_clamp_ff <= rsp_clamp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_temperature_c = rsp_temp_ff;
   assign rsp_clamp_status  = rsp_clamp_ff;

endmodule

// File: hw/rtl/tadc_checker.sv
// port level checks for the thermistor temperature block, bound to the top level
module tadc_checker
   import tadc_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_valid,
   input logic signed [TEMP_W-1:0] rsp_temperature_c,
   input logic [CLAMP_W-1:0]       rsp_clamp_status
);

   // a taken command keeps the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a command word");

   // a result comes only out of work in progress
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word without a command in progress");

   // never two result words in a row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a cold clamp reports the coldest temperature
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_clamp_status == CLAMP_COLD)) |-> (rsp_temperature_c == FIRST_TEMP))
      else $error("cold clamp with wrong temperature");

   // status code and temperature stay in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_clamp_status == CLAMP_NONE || rsp_clamp_status == CLAMP_COLD ||
                      rsp_clamp_status == CLAMP_HOT) &&
                     (rsp_temperature_c >= FIRST_TEMP) && (rsp_temperature_c <= 8'sd110)))
      else $error("result word out of range");

endmodule

bind thermistor_adc_to_temperature_core tadc_checker u_tadc_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_temperature_c (rsp_temperature_c),
   .rsp_clamp_status  (rsp_clamp_status)
);
